/* rtl/core/ptc_pkg.sv */
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and partial-product helpers for the pressure and
// temperature compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 64;
	localparam int FRONT_STAGES = 13;
	localparam int DIV_STAGES   = 64;
	localparam int BACK_STAGES  = 7;
	localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

	localparam logic [16:0] K_P_SCALE = 17'd3125;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAL_T1       = 3'd0,
		REG_CAL_T2_T3    = 3'd1,
		REG_CAL_P1       = 3'd2,
		REG_CAL_P2_TO_P5 = 3'd3,
		REG_CAL_P6_TO_P9 = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} cal_regs_t;

	// divider working word; on entry n is |dividend|, on exit |quotient|
	typedef struct packed {
		logic [63:0] n;
		logic [30:0] r;
		logic [30:0] ub;
		logic        neg;
		logic        nz;
		logic [31:0] tf;
		logic [31:0] tc;
	} div_word_t;

	function automatic logic [16:0] sx17(input logic [15:0] w);
		return {w[15], w};
	endfunction

	// 32-bit unsigned slice times 17-bit signed coefficient, sign-extended to 64
	function automatic logic [63:0] mul_part(input logic [31:0] x, input logic [16:0] c);
		logic signed [49:0] p;
		p = $signed({1'b0, x}) * $signed(c);
		return {{14{p[49]}}, p};
	endfunction

	function automatic logic [63:0] join_parts(input logic [63:0] lo, input logic [31:0] hi);
		return lo + {hi, 32'd0};
	endfunction

endpackage

`default_nettype wire

/* rtl/core/ptc_front.sv */
// ----------------------------------------------------------------------------
// ptc_front
// Temperature path and pressure coefficient stages: fine temperature,
// centidegrees, the dividend and the divisor, split into sign and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_vld,
	input  wire logic [19:0]         raw_temperature,
	input  wire logic [19:0]         raw_pressure,
	input  wire ptc_pkg::cal_regs_t  cal,
	output logic                     out_vld,
	output ptc_pkg::div_word_t       out_word
);
	import ptc_pkg::*;

	logic [12:0] vld_q;

	logic [17:0] a_s1;
	logic [16:0] b_s1;
	logic [20:0] pd_s1, pd_s2, pd_s3, pd_s4, pd_s5, pd_s6, pd_s7, pd_s8, pd_s9;
	logic [33:0] m1_s2, bb_s2;
	logic signed [31:0] v1t_s3;
	logic [35:0] m2_s3;
	logic [31:0] tf_s4, tf_s5, tf_s6, tf_s7, tf_s8, tf_s9, tf_s10, tf_s11, tf_s12;
	logic [31:0] tc_s5, tc_s6, tc_s7, tc_s8, tc_s9, tc_s10, tc_s11, tc_s12;
	logic signed [33:0] v1p_s5;
	logic [63:0] sq_s6, mp5_s6, mp2_s6, mp5_s7, mp2_s7, mp5_s8, mp2_s8;
	logic [63:0] x6lo_s7, x3lo_s7;
	logic [31:0] x6hi_s7, x3hi_s7;
	logic [63:0] x6_s8, x3_s8, v2_s9, v1_s9, wlo_s10, n0_s10, nlo_s11, num_s12;
	logic [31:0] whi_s10, nhi_s11;
	logic [30:0] d_s11, d_s12;

	logic signed [33:0] m1, bb;
	logic signed [31:0] v1t, bbs;
	logic signed [35:0] m2;
	logic [31:0] tf, t5, tc;
	logic signed [33:0] v1p;
	logic signed [67:0] sq;
	logic signed [49:0] mp5, mp2;
	logic [63:0] x6hi, x3hi, v2, v1, w, whi, n0, nhi, pv;

	always_comb begin
		m1   = $signed(a_s1) * $signed(cal.t2);
		bb   = $signed(b_s1) * $signed(b_s1);
		v1t  = $signed(m1_s2[31:0]) >>> 11;
		bbs  = $signed(bb_s2[31:0]) >>> 12;
		m2   = $signed(bbs[19:0]) * $signed(cal.t3);
		tf   = v1t_s3 + 32'($signed(m2_s3[31:0]) >>> 14);
		t5   = (tf_s4 << 2) + tf_s4 + 32'd128;
		tc   = 32'($signed(t5) >>> 8);
		v1p  = $signed(tf_s4) - 34'sd128000;
		sq   = v1p_s5 * v1p_s5;
		mp5  = v1p_s5 * $signed(cal.p5);
		mp2  = v1p_s5 * $signed(cal.p2);
		x6hi = mul_part(sq_s6[63:32], sx17(cal.p6));
		x3hi = mul_part(sq_s6[63:32], sx17(cal.p3));
		v2   = x6_s8 + (mp5_s8 << 17) + ({{48{cal.p4[15]}}, cal.p4} << 35);
		v1   = 64'($signed(x3_s8) >>> 8) + (mp2_s8 << 12);
		w    = 64'h0000_8000_0000_0000 + v1_s9;
		whi  = mul_part(w[63:32], {1'b0, cal.p1});
		n0   = ({43'd0, pd_s9} << 31) - v2_s9;
		nhi  = mul_part(n0_s10[63:32], K_P_SCALE);
		pv   = join_parts(wlo_s10, whi_s10);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[11:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= {1'b0, raw_temperature[19:3]} - {1'b0, cal.t1, 1'b0};
		b_s1    <= {1'b0, raw_temperature[19:4]} - {1'b0, cal.t1};
		pd_s1   <= 21'h100000 - {1'b0, raw_pressure};
		m1_s2   <= m1;
		bb_s2   <= bb;
		pd_s2   <= pd_s1;
		v1t_s3  <= v1t;
		m2_s3   <= m2;
		pd_s3   <= pd_s2;
		tf_s4   <= tf;
		pd_s4   <= pd_s3;
		tf_s5   <= tf_s4;
		tc_s5   <= tc;
		v1p_s5  <= v1p;
		pd_s5   <= pd_s4;
		sq_s6   <= sq[63:0];
		mp5_s6  <= {{14{mp5[49]}}, mp5};
		mp2_s6  <= {{14{mp2[49]}}, mp2};
		tf_s6   <= tf_s5;
		tc_s6   <= tc_s5;
		pd_s6   <= pd_s5;
		x6lo_s7 <= mul_part(sq_s6[31:0], sx17(cal.p6));
		x6hi_s7 <= x6hi[31:0];
		x3lo_s7 <= mul_part(sq_s6[31:0], sx17(cal.p3));
		x3hi_s7 <= x3hi[31:0];
		mp5_s7  <= mp5_s6;
		mp2_s7  <= mp2_s6;
		tf_s7   <= tf_s6;
		tc_s7   <= tc_s6;
		pd_s7   <= pd_s6;
		x6_s8   <= join_parts(x6lo_s7, x6hi_s7);
		x3_s8   <= join_parts(x3lo_s7, x3hi_s7);
		mp5_s8  <= mp5_s7;
		mp2_s8  <= mp2_s7;
		tf_s8   <= tf_s7;
		tc_s8   <= tc_s7;
		pd_s8   <= pd_s7;
		v2_s9   <= v2;
		v1_s9   <= v1;
		tf_s9   <= tf_s8;
		tc_s9   <= tc_s8;
		pd_s9   <= pd_s8;
		wlo_s10 <= mul_part(w[31:0], {1'b0, cal.p1});
		whi_s10 <= whi[31:0];
		n0_s10  <= n0;
		tf_s10  <= tf_s9;
		tc_s10  <= tc_s9;
		d_s11   <= pv[63:33];
		nlo_s11 <= mul_part(n0_s10[31:0], K_P_SCALE);
		nhi_s11 <= nhi[31:0];
		tf_s11  <= tf_s10;
		tc_s11  <= tc_s10;
		num_s12 <= join_parts(nlo_s11, nhi_s11);
		d_s12   <= d_s11;
		tf_s12  <= tf_s11;
		tc_s12  <= tc_s11;
		out_word.n   <= num_s12[63] ? (64'd0 - num_s12) : num_s12;
		out_word.r   <= '0;
		out_word.ub  <= d_s12[30] ? (31'd0 - d_s12) : d_s12;
		out_word.neg <= num_s12[63] ^ d_s12[30];
		out_word.nz  <= |d_s12;
		out_word.tf  <= tf_s12;
		out_word.tc  <= tc_s12;
	end

	assign out_vld = vld_q[12];

endmodule

`default_nettype wire

/* rtl/core/ptc_div.sv */
// ----------------------------------------------------------------------------
// ptc_div
// Unsigned restoring divider, one quotient bit per stage, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_vld,
	input  wire ptc_pkg::div_word_t  in_word,
	output logic                     out_vld,
	output ptc_pkg::div_word_t       out_word
);
	import ptc_pkg::*;

	logic      [DIV_STAGES-1:0] vld_sx;
	div_word_t                  word_sx [DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_step
		div_word_t   cur;
		div_word_t   nxt;
		logic        cur_vld;
		logic [31:0] r2, diff;

		if (i == 0) begin : g_first
			assign cur     = in_word;
			assign cur_vld = in_vld;
		end else begin : g_rest
			assign cur     = word_sx[i-1];
			assign cur_vld = vld_sx[i-1];
		end

		always_comb begin
			r2    = {cur.r, cur.n[63]};
			diff  = r2 - {1'b0, cur.ub};
			nxt   = cur;
			nxt.n = {cur.n[62:0], ~diff[31]};
			nxt.r = diff[31] ? r2[30:0] : diff[30:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sx[i] <= 1'b0;
			end else begin
				vld_sx[i] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			word_sx[i] <= nxt;
		end
	end

	assign out_vld  = vld_sx[DIV_STAGES-1];
	assign out_word = word_sx[DIV_STAGES-1];

endmodule

`default_nettype wire

/* rtl/core/ptc_back.sv */
// ----------------------------------------------------------------------------
// ptc_back
// Post-division correction of the pressure and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_vld,
	input  wire ptc_pkg::div_word_t  in_word,
	input  wire ptc_pkg::cal_regs_t  cal,
	output logic                     done,
	output logic [31:0]              fine_temperature,
	output logic [31:0]              temperature_centideg,
	output logic [23:0]              pressure_pa,
	output logic                     pressure_valid
);
	import ptc_pkg::*;

	logic [5:0] vld_q;

	logic [63:0] q_s1, q_s2, q_s3, q_s4, q_s5, t_s6;
	logic        nz_s1, nz_s2, nz_s3, nz_s4, nz_s5, nz_s6;
	logic [31:0] tf_s1, tf_s2, tf_s3, tf_s4, tf_s5, tf_s6;
	logic [31:0] tc_s1, tc_s2, tc_s3, tc_s4, tc_s5, tc_s6;
	logic [63:0] s_s2, s_s3, alo_s2, blo_s2, a_s3, b_s3, pll_s4, v2_s4, v1_s5, v2_s5;
	logic [31:0] ahi_s2, bhi_s2, plh_s4, phl_s4;

	logic [63:0] s, ahi, bhi, pll, plh, phl, prod, pf;

	always_comb begin
		s    = 64'($signed(q_s1) >>> 13);
		ahi  = mul_part(s[63:32], sx17(cal.p9));
		bhi  = mul_part(q_s1[63:32], sx17(cal.p8));
		pll  = a_s3[31:0] * s_s3[31:0];
		plh  = a_s3[31:0] * s_s3[63:32];
		phl  = a_s3[63:32] * s_s3[31:0];
		prod = pll_s4 + {plh_s4 + phl_s4, 32'd0};
		pf   = 64'($signed(t_s6) >>> 8) + ({{48{cal.p7[15]}}, cal.p7} << 4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q          <= '0;
			done           <= 1'b0;
			pressure_valid <= 1'b0;
		end else begin
			vld_q          <= {vld_q[4:0], in_vld};
			done           <= vld_q[5];
			pressure_valid <= vld_q[5] & nz_s6;
		end
	end

	always_ff @(posedge clk) begin
		q_s1   <= in_word.neg ? (64'd0 - in_word.n) : in_word.n;
		nz_s1  <= in_word.nz;
		tf_s1  <= in_word.tf;
		tc_s1  <= in_word.tc;
		s_s2   <= s;
		alo_s2 <= mul_part(s[31:0], sx17(cal.p9));
		ahi_s2 <= ahi[31:0];
		blo_s2 <= mul_part(q_s1[31:0], sx17(cal.p8));
		bhi_s2 <= bhi[31:0];
		q_s2   <= q_s1;
		nz_s2  <= nz_s1;
		tf_s2  <= tf_s1;
		tc_s2  <= tc_s1;
		a_s3   <= join_parts(alo_s2, ahi_s2);
		b_s3   <= join_parts(blo_s2, bhi_s2);
		s_s3   <= s_s2;
		q_s3   <= q_s2;
		nz_s3  <= nz_s2;
		tf_s3  <= tf_s2;
		tc_s3  <= tc_s2;
		pll_s4 <= pll;
		plh_s4 <= plh[31:0];
		phl_s4 <= phl[31:0];
		v2_s4  <= 64'($signed(b_s3) >>> 19);
		q_s4   <= q_s3;
		nz_s4  <= nz_s3;
		tf_s4  <= tf_s3;
		tc_s4  <= tc_s3;
		v1_s5  <= 64'($signed(prod) >>> 25);
		v2_s5  <= v2_s4;
		q_s5   <= q_s4;
		nz_s5  <= nz_s4;
		tf_s5  <= tf_s4;
		tc_s5  <= tc_s4;
		t_s6   <= q_s5 + v1_s5 + v2_s5;
		nz_s6  <= nz_s5;
		tf_s6  <= tf_s5;
		tc_s6  <= tc_s5;
		fine_temperature     <= tf_s6;
		temperature_centideg <= tc_s6;
		pressure_pa          <= nz_s6 ? pf[31:8] : 24'd0;
	end

endmodule

`default_nettype wire

/* rtl/core/pressure_temperature_compensation_unit.sv */
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_unit
// Integer compensation of raw temperature and pressure readings.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy never rises.
// Each request gives one result, strobed by done for one cycle, after it
// passes 13 stages of temperature and coefficient arithmetic, a
// 64-stage one-bit-per-stage divider and 7 stages of pressure correction.
// The receiver cannot stall and results are never held. Calibration writes
// take effect at once and must only be made with no request in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_temperature_compensation_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [19:0]                     raw_temperature,
	input  wire logic [19:0]                     raw_pressure,
	input  wire logic                            cfg_we,
	input  wire logic [ptc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ptc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output logic                                 done,
	output logic [31:0]                          fine_temperature,
	output logic [31:0]                          temperature_centideg,
	output logic [23:0]                          pressure_pa,
	output logic                                 pressure_valid
);
	import ptc_pkg::*;

	logic [15:0] cal_t1_q, cal_p1_q;
	logic [31:0] cal_t2_t3_q;
	logic [63:0] cal_p2_to_p5_q, cal_p6_to_p9_q;

	cal_regs_t cal;
	logic      front_vld, div_vld;
	div_word_t front_word, div_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t1_q       <= '0;
			cal_t2_t3_q    <= '0;
			cal_p1_q       <= '0;
			cal_p2_to_p5_q <= '0;
			cal_p6_to_p9_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAL_T1:       cal_t1_q       <= cfg_wdata[15:0];
				REG_CAL_T2_T3:    cal_t2_t3_q    <= cfg_wdata[31:0];
				REG_CAL_P1:       cal_p1_q       <= cfg_wdata[15:0];
				REG_CAL_P2_TO_P5: cal_p2_to_p5_q <= cfg_wdata;
				REG_CAL_P6_TO_P9: cal_p6_to_p9_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		cal.t1 = cal_t1_q;
		cal.t2 = cal_t2_t3_q[15:0];
		cal.t3 = cal_t2_t3_q[31:16];
		cal.p1 = cal_p1_q;
		cal.p2 = cal_p2_to_p5_q[15:0];
		cal.p3 = cal_p2_to_p5_q[31:16];
		cal.p4 = cal_p2_to_p5_q[47:32];
		cal.p5 = cal_p2_to_p5_q[63:48];
		cal.p6 = cal_p6_to_p9_q[15:0];
		cal.p7 = cal_p6_to_p9_q[31:16];
		cal.p8 = cal_p6_to_p9_q[47:32];
		cal.p9 = cal_p6_to_p9_q[63:48];
	end

	assign busy = 1'b0;

	ptc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_vld          (start & ~busy),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.cal             (cal),
		.out_vld         (front_vld),
		.out_word        (front_word)
	);

	ptc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (front_vld),
		.in_word  (front_word),
		.out_vld  (div_vld),
		.out_word (div_word)
	);

	ptc_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_vld               (div_vld),
		.in_word              (div_word),
		.cal                  (cal),
		.done                 (done),
		.fine_temperature     (fine_temperature),
		.temperature_centideg (temperature_centideg),
		.pressure_pa          (pressure_pa),
		.pressure_valid       (pressure_valid)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##PIPE_DEPTH done)
		else $error("request did not complete after the pipeline depth");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_DEPTH))
		else $error("result without a matching request");

	a_valid_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		pressure_valid |-> done)
		else $error("pressure_valid outside a result cycle");

	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		done && !pressure_valid |-> pressure_pa == 24'd0)
		else $error("pressure not cleared on zero divisor");

endmodule

`default_nettype wire
